// ===== rtl/ptts_pkg.sv =====
package ptts_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // per-slot control for one processed word
  typedef struct packed {
    logic tick;
    logic load;
    logic drop;
  } lane_ctrl_t;

  localparam int unsigned CMD_W        = 2;
  localparam int unsigned PERIOD_IN_W  = 16;
  localparam int unsigned SLOT_IN_W    = 3;
  localparam int unsigned FIRE_OUT_W   = 8;
  localparam int unsigned GIVEN_OUT_W  = 3;

endpackage

// ===== rtl/ptts_lane.sv =====
module ptts_lane #(
  parameter int unsigned PERIOD_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ptts_pkg::lane_ctrl_t     ctrl,
  input  logic [PERIOD_BITS-1:0]   load_period,
  output logic                     used,
  output logic                     fire
);

  logic [PERIOD_BITS-1:0] count;
  logic [PERIOD_BITS-1:0] per;
  logic [PERIOD_BITS-1:0] cnt_inc;
  logic [PERIOD_BITS-1:0] count_next;
  logic                   per_zero;

  // count stays below per, so count + 1 never overflows PERIOD_BITS
  assign cnt_inc    = count + PERIOD_BITS'(1);
  assign per_zero   = (per == '0);
  assign count_next = per_zero ? '0 : ((cnt_inc == per) ? '0 : cnt_inc);
  assign fire       = ctrl.tick && used && !per_zero &&
                      (count_next == (per - PERIOD_BITS'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctrl.load) begin
      used <= 1'b1;
    end else if (ctrl.drop) begin
      used <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      count <= '0;
      per   <= load_period;
    end else if (ctrl.tick && used) begin
      count <= count_next;
    end
  end

endmodule

// ===== rtl/ptts_alloc.sv =====
module ptts_alloc #(
  parameter int unsigned NUM_SLOTS = 8,
  parameter int unsigned SLOT_W    = 3
) (
  input  logic [NUM_SLOTS-1:0] used,
  output logic                 found,
  output logic [SLOT_W-1:0]    idx,
  output logic [NUM_SLOTS-1:0] grant
);

  // lowest free slot wins: scan downward so the last hit is the lowest
  always_comb begin
    found = 1'b0;
    idx   = '0;
    grant = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        found = 1'b1;
        idx   = SLOT_W'(i);
        grant = NUM_SLOTS'(1) << i;
      end
    end
  end

endmodule

// ===== rtl/periodic_task_tick_scheduler_core.sv =====
// Periodic task tick scheduler. A table of NUM_SLOTS task slots takes one command word
// per cycle: tick advances every occupied slot's counter modulo its period and reports
// the slots that reach period minus one in fire_mask; add places a period in the lowest
// free slot and reports it in slot_given (accepted low when the table is full); delete
// frees one slot; clear frees all. A period of zero never fires. Each word passes an
// input register, then all slot lanes and the free-slot encoder update in parallel
// into the result register. Throughput is one word per clock unless out_ready stalls;
// in_ready follows out_ready combinationally when both registers are full.
module periodic_task_tick_scheduler_core #(
  parameter int unsigned NUM_SLOTS   = 8,
  parameter int unsigned PERIOD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ptts_pkg::CMD_W-1:0]         cmd,
  input  logic [ptts_pkg::PERIOD_IN_W-1:0]   period,
  input  logic [ptts_pkg::SLOT_IN_W-1:0]     slot,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ptts_pkg::FIRE_OUT_W-1:0]    fire_mask,
  output logic [ptts_pkg::GIVEN_OUT_W-1:0]   slot_given,
  output logic                               accepted
);

  localparam int unsigned SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned FIRE_W  = (NUM_SLOTS > ptts_pkg::FIRE_OUT_W) ?
                                    NUM_SLOTS : ptts_pkg::FIRE_OUT_W;
  localparam int unsigned GIVEN_W = (SLOT_W > ptts_pkg::GIVEN_OUT_W) ?
                                    SLOT_W : ptts_pkg::GIVEN_OUT_W;

  // input register
  logic                               s1_valid;
  ptts_pkg::cmd_t                     s1_cmd;
  logic [PERIOD_BITS-1:0]             s1_period;
  logic [ptts_pkg::SLOT_IN_W-1:0]     s1_slot;

  logic                               advance;
  logic [31:0]                        period_ext;

  logic [NUM_SLOTS-1:0]               used_vec;
  logic [NUM_SLOTS-1:0]               fire_vec;
  logic [NUM_SLOTS-1:0]               grant;
  logic                               found;
  logic [SLOT_W-1:0]                  free_idx;
  logic [FIRE_W-1:0]                  fire_ext;
  logic [GIVEN_W-1:0]                 given_ext;
  ptts_pkg::lane_ctrl_t               lane_ctrl [NUM_SLOTS];

  logic                               is_tick;
  logic                               is_add;
  logic                               is_del;
  logic                               is_clear;

  logic [ptts_pkg::FIRE_OUT_W-1:0]    fire_mask_next;
  logic [ptts_pkg::GIVEN_OUT_W-1:0]   slot_given_next;
  logic                               accepted_next;

  assign advance    = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || advance;
  assign period_ext = 32'(period);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd    <= ptts_pkg::cmd_t'(cmd);
      s1_period <= period_ext[PERIOD_BITS-1:0];
      s1_slot   <= slot;
    end
  end

  always_comb begin
    is_tick  = 1'b0;
    is_add   = 1'b0;
    is_del   = 1'b0;
    is_clear = 1'b0;
    unique case (s1_cmd)
      ptts_pkg::CMD_TICK:   is_tick  = advance;
      ptts_pkg::CMD_ADD:    is_add   = advance;
      ptts_pkg::CMD_DELETE: is_del   = advance;
      ptts_pkg::CMD_CLEAR:  is_clear = advance;
      default: ;
    endcase
  end

  ptts_alloc #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_alloc (
    .used  (used_vec),
    .found (found),
    .idx   (free_idx),
    .grant (grant)
  );

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_lane
    // an out-of-range delete matches no lane and is dropped
    assign lane_ctrl[i].tick = is_tick;
    assign lane_ctrl[i].load = is_add && grant[i];
    assign lane_ctrl[i].drop = is_clear || (is_del && (32'(s1_slot) == i));

    ptts_lane #(
      .PERIOD_BITS (PERIOD_BITS)
    ) u_lane (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (lane_ctrl[i]),
      .load_period (s1_period),
      .used        (used_vec[i]),
      .fire        (fire_vec[i])
    );
  end

  assign fire_ext  = FIRE_W'(fire_vec);
  assign given_ext = GIVEN_W'(free_idx);

  always_comb begin
    fire_mask_next  = '0;
    slot_given_next = '0;
    accepted_next   = 1'b1;
    if (is_tick) begin
      fire_mask_next = fire_ext[ptts_pkg::FIRE_OUT_W-1:0];
    end
    if (is_add) begin
      accepted_next = found;
      if (found) begin
        slot_given_next = given_ext[ptts_pkg::GIVEN_OUT_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fire_mask  <= fire_mask_next;
      slot_given <= slot_given_next;
      accepted   <= accepted_next;
    end
  end

endmodule

// ===== rtl/ptts_checker.sv =====
module ptts_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [ptts_pkg::FIRE_OUT_W-1:0]    fire_mask,
  input logic [ptts_pkg::GIVEN_OUT_W-1:0]   slot_given,
  input logic                               accepted
);

  // no result may appear straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fire_mask) &&
                                $stable(slot_given) && $stable(accepted))
    else $error("stalled result changed");

  // a full-table add reports nothing else
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> slot_given == '0 && fire_mask == '0)
    else $error("rejected add carries data");

  // firing only comes from ticks, which give no slot
  a_fire_is_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && fire_mask != '0 |-> accepted && slot_given == '0)
    else $error("fire mask on a non-tick result");

  // with both registers drained the input side must be open
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !in_valid && !out_valid |=> in_ready)
    else $error("input blocked with empty pipeline");

endmodule

bind periodic_task_tick_scheduler_core ptts_checker u_ptts_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .fire_mask  (fire_mask),
  .slot_given (slot_given),
  .accepted   (accepted)
);

// ===== dv/periodic_task_tick_scheduler_core_test.sv =====
module periodic_task_tick_scheduler_core_test;

  localparam int unsigned NUM_SLOTS    = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned MAX_WAIT     = 14;

  typedef struct packed {
    logic [ptts_pkg::FIRE_OUT_W-1:0]  fire;
    logic [ptts_pkg::GIVEN_OUT_W-1:0] given;
    logic                             ok;
  } sched_result_t;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  logic [ptts_pkg::CMD_W-1:0]       cmd       = '0;
  logic [ptts_pkg::PERIOD_IN_W-1:0] period    = '0;
  logic [ptts_pkg::SLOT_IN_W-1:0]   slot      = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [ptts_pkg::FIRE_OUT_W-1:0]  fire_mask;
  logic [ptts_pkg::GIVEN_OUT_W-1:0] slot_given;
  logic                             accepted;

  // shadow of the slot table
  bit          task_live   [NUM_SLOTS] = '{default: 1'b0};
  logic [15:0] tick_cnt    [NUM_SLOTS] = '{default: '0};
  logic [15:0] task_period [NUM_SLOTS] = '{default: '0};

  sched_result_t pending_results[$];
  sched_result_t oldest;
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   next_gap    = 0;
  int unsigned   out_hold    = 0;
  bit            valid_kept  = 1'b0;
  bit            no_idle     = 1'b0;

  always #2 clk = ~clk;

  periodic_task_tick_scheduler_core #(
    .NUM_SLOTS   (NUM_SLOTS),
    .PERIOD_BITS (16)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .period     (period),
    .slot       (slot),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .fire_mask  (fire_mask),
    .slot_given (slot_given),
    .accepted   (accepted)
  );

  function automatic int unsigned draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic sched_result_t schedule_step(ptts_pkg::cmd_t c, logic [15:0] p,
                                                  logic [2:0] s);
    sched_result_t r;
    logic [16:0]   nxt;
    logic          found;
    r     = '0;
    r.ok  = 1'b1;
    found = 1'b0;
    case (c)
      ptts_pkg::CMD_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (task_live[i]) begin
            if (task_period[i] == 16'd0) begin
              tick_cnt[i] = '0;
            end else begin
              nxt = ({1'b0, tick_cnt[i]} + 17'd1) % {1'b0, task_period[i]};
              tick_cnt[i] = nxt[15:0];
              if (nxt == {1'b0, task_period[i]} - 17'd1) r.fire[i] = 1'b1;
            end
          end
        end
      end
      ptts_pkg::CMD_ADD: begin
        r.ok = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!found && !task_live[i]) begin
            task_live[i]   = 1'b1;
            tick_cnt[i]    = '0;
            task_period[i] = p;
            r.given        = i[2:0];
            r.ok           = 1'b1;
            found          = 1'b1;
          end
        end
      end
      ptts_pkg::CMD_DELETE: begin
        if (s < NUM_SLOTS) task_live[s] = 1'b0;
      end
      default: begin
        for (int i = 0; i < NUM_SLOTS; i++) task_live[i] = 1'b0;
      end
    endcase
    return r;
  endfunction

  // Hold valid across back-to-back words; drop it only when a gap follows.
  task automatic send_word(ptts_pkg::cmd_t c, logic [15:0] p, logic [2:0] s);
    repeat (next_gap) @(posedge clk);
    in_valid <= 1'b1;
    cmd      <= c;
    period   <= p;
    slot     <= s;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(schedule_step(c, p, s));
    next_gap   = draw_gap();
    valid_kept = (next_gap == 0);
    if (!valid_kept) in_valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    if (valid_kept) begin
      in_valid  <= 1'b0;
      valid_kept = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic send_random_word();
    int unsigned    pick;
    ptts_pkg::cmd_t c;
    logic [15:0]    p;
    pick = $urandom_range(0, 99);
    p    = 16'($urandom_range(0, 16'hFFFF));
    if (pick < 55) begin
      c = ptts_pkg::CMD_TICK;
    end else if (pick < 80) begin
      c = ptts_pkg::CMD_ADD;
      // mostly short periods so slots wrap and fire often
      if ($urandom_range(0, 9) < 7) p = 16'($urandom_range(0, 9));
    end else if (pick < 96) begin
      c = ptts_pkg::CMD_DELETE;
    end else begin
      c = ptts_pkg::CMD_CLEAR;
    end
    send_word(c, p, 3'($urandom_range(0, 7)));
  endtask

  task automatic test_empty_table();
    send_word(ptts_pkg::CMD_TICK, 16'hFFFF, 3'd7);
    send_word(ptts_pkg::CMD_TICK, 16'h0000, 3'd0);
    wait_quiet();
  endtask

  task automatic test_fill_table();
    send_word(ptts_pkg::CMD_ADD, 16'd1, 3'd0);
    send_word(ptts_pkg::CMD_ADD, 16'd2, 3'd0);
    send_word(ptts_pkg::CMD_ADD, 16'd3, 3'd0);
    send_word(ptts_pkg::CMD_ADD, 16'd0, 3'd0);
    send_word(ptts_pkg::CMD_ADD, 16'hFFFF, 3'd0);
    send_word(ptts_pkg::CMD_ADD, 16'hAAAA, 3'd0);
    send_word(ptts_pkg::CMD_ADD, 16'h5555, 3'd0);
    send_word(ptts_pkg::CMD_ADD, 16'h8000, 3'd0);
    // table is full now
    send_word(ptts_pkg::CMD_ADD, 16'd7, 3'd0);
    repeat (4) send_word(ptts_pkg::CMD_TICK, 16'd0, 3'd0);
    wait_quiet();
  endtask

  task automatic test_delete_slots();
    send_word(ptts_pkg::CMD_DELETE, 16'd0, 3'd3);
    send_word(ptts_pkg::CMD_DELETE, 16'd0, 3'd3);
    send_word(ptts_pkg::CMD_ADD, 16'd2, 3'd5);
    repeat (2) send_word(ptts_pkg::CMD_TICK, 16'd0, 3'd0);
    wait_quiet();
  endtask

  task automatic test_clear_table();
    send_word(ptts_pkg::CMD_CLEAR, 16'h1234, 3'd2);
    send_word(ptts_pkg::CMD_TICK, 16'd0, 3'd0);
    send_word(ptts_pkg::CMD_ADD, 16'd1, 3'd0);
    send_word(ptts_pkg::CMD_TICK, 16'd0, 3'd0);
    wait_quiet();
  endtask

  task automatic test_random_traffic(int unsigned n);
    repeat (n) send_random_word();
    wait_quiet();
  endtask

  task automatic test_back_to_back(int unsigned n);
    no_idle = 1'b1;
    repeat (n) send_random_word();
    wait_quiet();
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** periodic_task_tick_scheduler_core: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected word fire_mask=%h slot_given=%0d accepted=%0b",
                   $time, fire_mask, slot_given, accepted);
          error_count++;
        end else begin
          oldest = pending_results.pop_front();
          if (fire_mask !== oldest.fire) begin
            $display("%0t: fire_mask expected %h actual %h", $time, oldest.fire, fire_mask);
            error_count++;
          end
          if (slot_given !== oldest.given) begin
            $display("%0t: slot_given expected %0d actual %0d",
                     $time, oldest.given, slot_given);
            error_count++;
          end
          if (accepted !== oldest.ok) begin
            $display("%0t: accepted expected %0b actual %0b", $time, oldest.ok, accepted);
            error_count++;
          end
        end
        out_hold = draw_gap();
        out_ready <= (out_hold == 0);
      end else if (!out_ready) begin
        if (out_hold <= 1) begin
          out_hold = 0;
          out_ready <= 1'b1;
        end else begin
          out_hold--;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_fill_table();
    test_delete_slots();
    test_clear_table();
    test_random_traffic(450);
    test_back_to_back(100);
    if (error_count == 0) begin
      $display("** periodic_task_tick_scheduler_core: PASSED **");
    end else begin
      $display("** periodic_task_tick_scheduler_core: FAILED **");
    end
    $finish;
  end

endmodule
